@@ rtl/rhc_pkg.sv @@
// Package with payload types and constants for the RGB to HSV converter.
`default_nettype none
package rhc_pkg;

    localparam int unsigned HUE_SEXTANT = 3840;
    localparam int unsigned HUE_FULL    = 23040;

    // Sextant of the largest channel.
    localparam logic [1:0] SEXT_RED   = 2'd0;
    localparam logic [1:0] SEXT_GREEN = 2'd1;
    localparam logic [1:0] SEXT_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [14:0] hue_out;
        logic [15:0] sat_out;
        logic [7:0]  val_out;
    } t_pix_out;

    // Work carried from one divider cell to the next.
    typedef struct packed {
        logic        vld;
        logic [7:0]  den_h;     // max channel, divisor for saturation
        logic [7:0]  den_d;     // delta, divisor for hue
        logic [23:0] rem_s;     // partial remainder, saturation
        logic [23:0] rem_h;     // partial remainder, hue magnitude
        logic [15:0] quo_s;
        logic [15:0] quo_h;     // top four bits stay clear unless the pixel is grey
        logic        neg;       // hue difference was negative
        logic [1:0]  sext;
        logic        grey;
        logic [7:0]  val;
    } t_cell;

endpackage
`default_nettype wire

@@ rtl/rhc_cell.sv @@
// One restoring-division cell: one quotient bit for saturation and hue.
`default_nettype none
module rhc_cell #(
    parameter int SBIT = 0,
    parameter int HBIT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rhc_pkg::t_cell i_cell,
    output rhc_pkg::t_cell      o_cell
);
    rhc_pkg::t_cell r_cell;
    rhc_pkg::t_cell n_cell;
    logic [23:0] w_ds;
    logic [23:0] w_dh;

    always_comb begin
        n_cell = i_cell;
        w_ds   = 24'(i_cell.den_h) << SBIT;
        w_dh   = 24'(i_cell.den_d) << HBIT;
        if (i_cell.rem_s >= w_ds) begin
            n_cell.rem_s       = i_cell.rem_s - w_ds;
            n_cell.quo_s[SBIT] = 1'b1;
        end
        if (i_cell.rem_h >= w_dh) begin
            n_cell.rem_h       = i_cell.rem_h - w_dh;
            n_cell.quo_h[HBIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= i_cell.vld;
        end
        r_cell.den_h <= n_cell.den_h;
        r_cell.den_d <= n_cell.den_d;
        r_cell.rem_s <= n_cell.rem_s;
        r_cell.rem_h <= n_cell.rem_h;
        r_cell.quo_s <= n_cell.quo_s;
        r_cell.quo_h <= n_cell.quo_h;
        r_cell.neg   <= n_cell.neg;
        r_cell.sext  <= n_cell.sext;
        r_cell.grey  <= n_cell.grey;
        r_cell.val   <= n_cell.val;
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

@@ rtl/rgb_to_hsv_convert.sv @@
// Top level of the RGB to HSV converter: front stage, divider cell row, output stage.
//
//  channel | signals                 | direction | beat
//  pixel   | i_start, o_busy, i_pix  | in        | start && !busy
//  result  | o_done, o_hsv           | out       | done high one cycle
//
// One pixel is accepted every cycle; o_busy is held low outside reset.
// The pipeline has one front stage, sixteen divider cells (one
// quotient bit each for saturation, hue bits in the low twelve), and one output stage.
// Reset is synchronous and clears the front stage and the valid bits.
// The receiver cannot stall, so no result is ever held.
`default_nettype none
module rgb_to_hsv_convert (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire rhc_pkg::t_pix_in  i_pix,
    output logic                   o_done,
    output rhc_pkg::t_pix_out      o_hsv
);
    localparam int NCELL = 16;

    rhc_pkg::t_cell w_chain [NCELL+1];
    rhc_pkg::t_cell r_head;
    rhc_pkg::t_cell n_head;
    logic [7:0] w_r, w_g, w_b, w_hi, w_lo, w_dif;
    logic       w_neg;
    logic [1:0] w_sx;

    assign w_r = i_pix.red_in;
    assign w_g = i_pix.green_in;
    assign w_b = i_pix.blue_in;

    always_comb begin
        w_hi = (w_r >= w_g) ? w_r : w_g;
        if (w_b > w_hi) w_hi = w_b;
        w_lo = (w_r <= w_g) ? w_r : w_g;
        if (w_b < w_lo) w_lo = w_b;
        if (w_r == w_hi) begin
            w_sx  = rhc_pkg::SEXT_RED;
            w_neg = w_g < w_b;
            w_dif = w_neg ? w_b - w_g : w_g - w_b;
        end else if (w_g == w_hi) begin
            w_sx  = rhc_pkg::SEXT_GREEN;
            w_neg = w_b < w_r;
            w_dif = w_neg ? w_r - w_b : w_b - w_r;
        end else begin
            w_sx  = rhc_pkg::SEXT_BLUE;
            w_neg = w_r < w_g;
            w_dif = w_neg ? w_g - w_r : w_r - w_g;
        end
        n_head       = '0;
        n_head.vld   = i_start;
        n_head.den_h = w_hi;
        n_head.den_d = w_hi - w_lo;
        n_head.rem_s = 24'(w_hi - w_lo) * 24'd65535;
        n_head.rem_h = 24'(w_dif) * 24'(rhc_pkg::HUE_SEXTANT);
        n_head.neg   = w_neg;
        n_head.sext  = w_sx;
        n_head.grey  = (w_hi == w_lo);
        n_head.val   = w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    assign w_chain[0] = r_head;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rhc_cell #(.SBIT(NCELL-1-k), .HBIT(NCELL-1-k)) u_cell (
            .i_clk (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell(w_chain[k]),
            .o_cell(w_chain[k+1])
        );
    end

    rhc_pkg::t_cell w_t;
    logic [15:0] w_base, w_hue;
    logic        r_done;
    rhc_pkg::t_pix_out r_hsv;

    assign w_t = w_chain[NCELL];

    always_comb begin
        case (w_t.sext)
            rhc_pkg::SEXT_GREEN: w_base = 16'(2 * rhc_pkg::HUE_SEXTANT);
            rhc_pkg::SEXT_BLUE:  w_base = 16'(4 * rhc_pkg::HUE_SEXTANT);
            default:             w_base = 16'(rhc_pkg::HUE_FULL);
        endcase
        if (w_t.neg) w_hue = w_base - w_t.quo_h;
        else         w_hue = w_base + w_t.quo_h;
        if (w_t.sext == rhc_pkg::SEXT_RED && !w_t.neg) w_hue = w_t.quo_h;
        if (w_hue >= 16'(rhc_pkg::HUE_FULL)) w_hue = w_hue - 16'(rhc_pkg::HUE_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_t.vld;
        end
        r_hsv.hue_out <= w_t.grey ? '0 : w_hue[14:0];
        r_hsv.sat_out <= w_t.grey ? '0 : w_t.quo_s;
        r_hsv.val_out <= w_t.val;
    end

    assign o_busy = !i_rst_n;
    assign o_done = r_done;
    assign o_hsv  = r_hsv;

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_hsv.hue_out < 15'(rhc_pkg::HUE_FULL))
        else $error("hue out of range");
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hsv.val_out == 8'd0) |-> o_hsv.sat_out == 16'd0)
        else $error("black pixel with saturation");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_head.vld, 17) |-> o_done)
        else $error("result lost");
endmodule
`default_nettype wire

@@ dv/tb_rgb_to_hsv_convert.sv @@
// Self-checking testbench for the RGB to HSV converter with a queue-fed driver and a monitor.
`timescale 1ns / 1ps
module tb_rgb_to_hsv_convert;

    localparam int PIPE_LAT   = 18;
    localparam int CYCLE_CAP  = 200000;
    localparam int N_RANDOM   = 400;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    rhc_pkg::t_pix_in  i_pix = '0;
    logic              o_busy;
    logic              o_done;
    rhc_pkg::t_pix_out o_hsv;

    rhc_pkg::t_pix_in  pix_pending[$];
    rhc_pkg::t_pix_out hsv_expected[$];
    int       mismatch_cnt = 0;
    int       cycle_cnt = 0;
    bit       hold_sender = 1'b0;
    bit       calm_stretch = 1'b0;

    rgb_to_hsv_convert u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_pix   (i_pix),
        .o_done  (o_done),
        .o_hsv   (o_hsv)
    );

    always #5 i_clk = ~i_clk;

    function automatic rhc_pkg::t_pix_out hsv_of(rhc_pkg::t_pix_in p);
        int r, g, b, hi, lo, dl, hue;
        rhc_pkg::t_pix_out o;
        r = p.red_in;
        g = p.green_in;
        b = p.blue_in;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        dl = hi - lo;
        hue = 0;
        o.sat_out = '0;
        if (dl != 0) begin
            o.sat_out = 16'((65535 * dl) / hi);
            // SystemVerilog integer division truncates toward zero.
            if (r == hi) begin
                hue = (int'(rhc_pkg::HUE_SEXTANT) * (g - b)) / dl;
            end else if (g == hi) begin
                hue = 2 * int'(rhc_pkg::HUE_SEXTANT) +
                      (int'(rhc_pkg::HUE_SEXTANT) * (b - r)) / dl;
            end else begin
                hue = 4 * int'(rhc_pkg::HUE_SEXTANT) +
                      (int'(rhc_pkg::HUE_SEXTANT) * (r - g)) / dl;
            end
            if (hue < 0) begin
                hue += int'(rhc_pkg::HUE_FULL);
            end
        end
        o.hue_out = 15'(hue);
        o.val_out = 8'(hi);
        return o;
    endfunction

    function automatic rhc_pkg::t_pix_in mk_pix(int r, int g, int b);
        rhc_pkg::t_pix_in p;
        p.red_in = 8'(r);
        p.green_in = 8'(g);
        p.blue_in = 8'(b);
        return p;
    endfunction

    // Driver: a beat is taken at an edge with start high and busy low.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                hsv_expected.push_back(hsv_of(i_pix));
                void'(pix_pending.pop_front());
            end
            if (i_start && o_busy) begin
                // Beat still offered; keep it.
            end else if (pix_pending.size() > 0 && !hold_sender &&
                         (calm_stretch || $urandom_range(99) >= 23)) begin
                i_start <= 1'b1;
                i_pix   <= pix_pending[0];
            end else begin
                i_start <= 1'b0;
                i_pix   <= rhc_pkg::t_pix_in'(24'($urandom));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (hsv_expected.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10) begin
                    $display("unexpected result beat: %p", o_hsv);
                end
            end else begin
                if (o_hsv.hue_out !== hsv_expected[0].hue_out ||
                    o_hsv.sat_out !== hsv_expected[0].sat_out ||
                    o_hsv.val_out !== hsv_expected[0].val_out) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10) begin
                        $display("mismatch: expected %p got %p", hsv_expected[0], o_hsv);
                    end
                end
                void'(hsv_expected.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("rgb_to_hsv_convert regression: fail");
            $finish;
        end
    end

    initial begin
        int r, g, b, k;
        // Directed pixels: black, white, primaries, ties, negative hue wrap.
        pix_pending.push_back(mk_pix(0, 0, 0));
        pix_pending.push_back(mk_pix(255, 255, 255));
        pix_pending.push_back(mk_pix(128, 128, 128));
        pix_pending.push_back(mk_pix(255, 0, 0));
        pix_pending.push_back(mk_pix(0, 255, 0));
        pix_pending.push_back(mk_pix(0, 0, 255));
        pix_pending.push_back(mk_pix(255, 255, 0));
        pix_pending.push_back(mk_pix(0, 255, 255));
        pix_pending.push_back(mk_pix(255, 0, 255));
        pix_pending.push_back(mk_pix(200, 200, 10));
        pix_pending.push_back(mk_pix(10, 200, 200));
        pix_pending.push_back(mk_pix(200, 10, 200));
        pix_pending.push_back(mk_pix(255, 0, 1));
        pix_pending.push_back(mk_pix(255, 1, 0));
        pix_pending.push_back(mk_pix(1, 0, 0));
        pix_pending.push_back(mk_pix(1, 0, 1));
        pix_pending.push_back(mk_pix(254, 255, 253));
        pix_pending.push_back(mk_pix(0, 1, 255));
        pix_pending.push_back(mk_pix(170, 85, 255));
        pix_pending.push_back(mk_pix(1, 1, 0));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pix_pending.size() == 0);
        // Let every outstanding result drain before the random part.
        hold_sender = 1'b1;
        wait (hsv_expected.size() == 0);
        hold_sender = 1'b0;
        for (k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(255);
            g = $urandom_range(255);
            b = $urandom_range(255);
            case ($urandom_range(7))
                0: g = r;
                1: b = g;
                2: begin g = r; b = r; end
                3: b = r;
                default: ;
            endcase
            pix_pending.push_back(mk_pix(r, g, b));
        end
        wait (pix_pending.size() < N_RANDOM / 2);
        calm_stretch = 1'b1;
        wait (pix_pending.size() < N_RANDOM / 4);
        calm_stretch = 1'b0;
        wait (pix_pending.size() == 0);
        @(posedge i_clk);
        wait (hsv_expected.size() == 0);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && hsv_expected.size() == 0) begin
            $display("rgb_to_hsv_convert regression: pass");
        end else begin
            $display("rgb_to_hsv_convert regression: fail");
        end
        $finish;
    end
endmodule
